[rtl/core/bpc_pkg.sv]
// ----------------------------------------------------------------------------
// bpc_pkg
// Shared types, constants and the divider step for the pressure/temperature
// compensation pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package bpc_pkg;

    localparam int unsigned DIV_STEPS = 32;

    localparam logic [31:0] B6_OFS     = 32'd4000;
    localparam logic [31:0] K_3038     = 32'd3038;
    localparam logic [31:0] K_M7357    = 32'hFFFF_E343;  // -7357
    localparam logic [31:0] K_3791     = 32'd3791;
    localparam logic [31:0] PRESS_K    = 32'd50000;
    localparam logic [31:0] B4_OFS     = 32'd32768;

    localparam logic [1:0] REG_CAL0 = 2'd0;
    localparam logic [1:0] REG_CAL1 = 2'd1;
    localparam logic [1:0] REG_MCMD = 2'd2;
    localparam logic [1:0] REG_OSS  = 2'd3;

    // one restoring-division step: remainder, dividend/quotient shifter, divisor
    typedef struct packed {
        logic [31:0] rem;
        logic [31:0] num;
        logic [31:0] d;
    } t_div;

    typedef struct packed {
        logic [31:0] x1;
        logic [18:0] up;
        logic        err;
        logic        neg;
    } t_tside;

    typedef struct packed {
        logic [31:0] temp;
        logic        post;
        logic        err;
    } t_pside;

    function automatic t_div div_step(input t_div s);
        t_div        o;
        logic [32:0] sh;
        logic [32:0] df;
        sh    = {s.rem, s.num[31]};
        df    = sh - {1'b0, s.d};
        o.d   = s.d;
        if (!df[32]) begin
            o.rem = df[31:0];
            o.num = {s.num[30:0], 1'b1};
        end else begin
            o.rem = sh[31:0];
            o.num = {s.num[30:0], 1'b0};
        end
        return o;
    endfunction

endpackage

`default_nettype wire

[rtl/core/baro_pressure_temp_compensation_unit.sv]
// ----------------------------------------------------------------------------
// baro_pressure_temp_compensation_unit
// Integer compensation of raw barometer temperature and pressure words,
// fully pipelined with two bit-per-stage dividers.
// ----------------------------------------------------------------------------
//  channel   | dir | payload
//  s_axis    | in  | tdata[15:0] raw_temperature, [34:16] raw_pressure
//  m_axis    | out | tdata[31:0] temperature_tenths, [63:32] pressure_pa;
//            |     | tuser[0] div_error
//  apb       | in  | 0x00 cal_ac1_to_ac4, 0x08 cal_ac5_to_b2, 0x10 cal_mc_md,
//            |     | 0x18 oversampling
//
//  One request per cycle unless m_axis stalls; the pipeline is two dividers of
//  33 registers each plus 9 arithmetic stages incl. the output register.
//  Synchronous active-low reset clears all valid bits and the APB registers.
//  A stall at m_axis freezes the whole pipeline; s_axis_tready follows it.
// ----------------------------------------------------------------------------
`default_nettype none

module baro_pressure_temp_compensation_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,   // raw_temperature, raw_pressure
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [63:0]      m_axis_tdata,   // temperature_tenths, pressure_pa
    output logic [0:0]       m_axis_tuser,   // div_error
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [63:0] pwdata,
    output logic [63:0]      prdata,
    output logic             pready
);

    localparam int unsigned N = bpc_pkg::DIV_STEPS;

    logic [63:0] r_cal0, r_cal1;
    logic [31:0] r_mcmd;
    logic [1:0]  r_oss;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal0 <= '0;
            r_cal1 <= '0;
            r_mcmd <= '0;
            r_oss  <= '0;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[4:3])
                bpc_pkg::REG_CAL0: r_cal0 <= pwdata;
                bpc_pkg::REG_CAL1: r_cal1 <= pwdata;
                bpc_pkg::REG_MCMD: r_mcmd <= pwdata[31:0];
                bpc_pkg::REG_OSS:  r_oss  <= pwdata[1:0];
                default:           r_oss  <= r_oss;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:3])
            bpc_pkg::REG_CAL0: prdata = r_cal0;
            bpc_pkg::REG_CAL1: prdata = r_cal1;
            bpc_pkg::REG_MCMD: prdata = {32'd0, r_mcmd};
            bpc_pkg::REG_OSS:  prdata = {62'd0, r_oss};
            default:           prdata = '0;
        endcase
    end

    // calibration words
    logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
    assign ac1 = {{16{r_cal0[15]}}, r_cal0[15:0]};
    assign ac2 = {{16{r_cal0[31]}}, r_cal0[31:16]};
    assign ac3 = {{16{r_cal0[47]}}, r_cal0[47:32]};
    assign ac4 = {16'd0, r_cal0[63:48]};
    assign ac5 = {16'd0, r_cal1[15:0]};
    assign ac6 = {16'd0, r_cal1[31:16]};
    assign b1  = {{16{r_cal1[47]}}, r_cal1[47:32]};
    assign b2  = {{16{r_cal1[63]}}, r_cal1[63:48]};
    assign mc  = {{16{r_mcmd[15]}}, r_mcmd[15:0]};
    assign md  = {{16{r_mcmd[31]}}, r_mcmd[31:16]};

    logic w_en;
    logic r_ov;
    assign w_en          = !r_ov || m_axis_tready;
    assign s_axis_tready = w_en;

    // ---------------- stage 1: x1 of temperature
    logic        r_s1_v;
    logic [31:0] r_s1_x1;
    logic [18:0] r_s1_up;
    logic [31:0] w1_m;
    assign w1_m = ({16'd0, s_axis_tdata[15:0]} - ac6) * ac5;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (w_en) begin
            r_s1_v <= s_axis_tvalid;
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_x1 <= 32'($signed(w1_m) >>> 15);
            r_s1_up <= s_axis_tdata[34:16];
        end
    end

    // ---------------- stage 2 + temperature divider
    bpc_pkg::t_div   r_td [0:N];
    bpc_pkg::t_tside r_ts [0:N];
    logic [N:0]      r_tv;
    logic [31:0]     w2_n, w2_d;
    assign w2_n = mc << 11;
    assign w2_d = r_s1_x1 + md;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tv <= '0;
        end else if (w_en) begin
            r_tv <= {r_tv[N-1:0], r_s1_v};
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_td[0].rem <= '0;
            r_td[0].num <= w2_n[31] ? (32'd0 - w2_n) : w2_n;
            r_td[0].d   <= w2_d[31] ? (32'd0 - w2_d) : w2_d;
            r_ts[0].x1  <= r_s1_x1;
            r_ts[0].up  <= r_s1_up;
            r_ts[0].err <= (w2_d == 32'd0);
            r_ts[0].neg <= w2_n[31] ^ w2_d[31];
            for (int k = 0; k < N; k++) begin
                r_td[k+1] <= bpc_pkg::div_step(r_td[k]);
                r_ts[k+1] <= r_ts[k];
            end
        end
    end

    // ---------------- stage 3: b5, temperature, b6
    logic        r_s3_v, r_s3_err;
    logic [31:0] r_s3_temp, r_s3_b6;
    logic [18:0] r_s3_up;
    logic [31:0] w3_x2, w3_b5, w3_t;
    assign w3_x2 = r_ts[N].neg ? (32'd0 - r_td[N].num) : r_td[N].num;
    assign w3_b5 = r_ts[N].x1 + w3_x2;
    assign w3_t  = w3_b5 + 32'd8;

    // ---------------- stage 4: sq, ac2*b6, ac3*b6
    logic        r_s4_v, r_s4_err;
    logic [31:0] r_s4_temp, r_s4_sq, r_s4_a2, r_s4_a3;
    logic [18:0] r_s4_up;
    logic [31:0] w4_sq, w4_a2, w4_a3;
    assign w4_sq = r_s3_b6 * r_s3_b6;
    assign w4_a2 = ac2 * r_s3_b6;
    assign w4_a3 = ac3 * r_s3_b6;

    // ---------------- stage 5: b2*sq, b1*sq
    logic        r_s5_v, r_s5_err;
    logic [31:0] r_s5_temp, r_s5_x1, r_s5_x2, r_s5_a2, r_s5_a3;
    logic [18:0] r_s5_up;
    logic [31:0] w5_x1, w5_x2;
    assign w5_x1 = b2 * r_s4_sq;
    assign w5_x2 = b1 * r_s4_sq;

    // ---------------- stage 6: b3, x3
    logic        r_s6_v, r_s6_err;
    logic [31:0] r_s6_temp, r_s6_b3, r_s6_x3;
    logic [18:0] r_s6_up;
    logic [31:0] w6_s, w6_x3;
    assign w6_s  = (({ac1[29:0], 2'b00} + r_s5_x1 + r_s5_a2) << r_oss) + 32'd2;
    assign w6_x3 = r_s5_a3 + r_s5_x2 + 32'd2;

    // ---------------- stage 7: b4, b7
    logic        r_s7_v, r_s7_err;
    logic [31:0] r_s7_temp, r_s7_b4, r_s7_b7;
    logic [31:0] w7_b4;
    assign w7_b4 = ac4 * (r_s6_x3 + bpc_pkg::B4_OFS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_v <= 1'b0;
            r_s4_v <= 1'b0;
            r_s5_v <= 1'b0;
            r_s6_v <= 1'b0;
            r_s7_v <= 1'b0;
        end else if (w_en) begin
            r_s3_v <= r_tv[N];
            r_s4_v <= r_s3_v;
            r_s5_v <= r_s4_v;
            r_s6_v <= r_s5_v;
            r_s7_v <= r_s6_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s3_err  <= r_ts[N].err;
            r_s3_up   <= r_ts[N].up;
            r_s3_temp <= 32'($signed(w3_t) >>> 4);
            r_s3_b6   <= w3_b5 - bpc_pkg::B6_OFS;

            r_s4_err  <= r_s3_err;
            r_s4_up   <= r_s3_up;
            r_s4_temp <= r_s3_temp;
            r_s4_sq   <= 32'($signed(w4_sq) >>> 12);
            r_s4_a2   <= 32'($signed(w4_a2) >>> 11);
            r_s4_a3   <= 32'($signed(w4_a3) >>> 13);

            r_s5_err  <= r_s4_err;
            r_s5_up   <= r_s4_up;
            r_s5_temp <= r_s4_temp;
            r_s5_x1   <= 32'($signed(w5_x1) >>> 11);
            r_s5_x2   <= 32'($signed(w5_x2) >>> 16);
            r_s5_a2   <= r_s4_a2;
            r_s5_a3   <= r_s4_a3;

            r_s6_err  <= r_s5_err;
            r_s6_up   <= r_s5_up;
            r_s6_temp <= r_s5_temp;
            r_s6_b3   <= 32'($signed(w6_s) >>> 2);
            r_s6_x3   <= 32'($signed(w6_x3) >>> 2);

            r_s7_err  <= r_s6_err;
            r_s7_temp <= r_s6_temp;
            r_s7_b4   <= w7_b4 >> 15;
            r_s7_b7   <= ({13'd0, r_s6_up} - r_s6_b3) * (bpc_pkg::PRESS_K >> r_oss);
        end
    end

    // ---------------- stage 8 + pressure divider
    bpc_pkg::t_div   r_pd [0:N];
    bpc_pkg::t_pside r_ps [0:N];
    logic [N:0]      r_pv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= '0;
        end else if (w_en) begin
            r_pv <= {r_pv[N-1:0], r_s7_v};
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_pd[0].rem  <= '0;
            // top bit set: divide first and double afterwards
            r_pd[0].num  <= r_s7_b7[31] ? r_s7_b7 : (r_s7_b7 << 1);
            r_pd[0].d    <= r_s7_b4;
            r_ps[0].temp <= r_s7_temp;
            r_ps[0].post <= r_s7_b7[31];
            r_ps[0].err  <= r_s7_err || (r_s7_b4 == 32'd0);
            for (int k = 0; k < N; k++) begin
                r_pd[k+1] <= bpc_pkg::div_step(r_pd[k]);
                r_ps[k+1] <= r_ps[k];
            end
        end
    end

    // ---------------- stage 9: p, (p>>8)^2, -7357*p
    logic        r_s9_v, r_s9_err;
    logic [31:0] r_s9_temp, r_s9_p, r_s9_x1, r_s9_x2;
    logic [31:0] w9_p, w9_ps;
    assign w9_p  = r_ps[N].post ? (r_pd[N].num << 1) : r_pd[N].num;
    assign w9_ps = 32'($signed(w9_p) >>> 8);

    // ---------------- stage 10: x1*3038
    logic        r_s10_v, r_s10_err;
    logic [31:0] r_s10_temp, r_s10_p, r_s10_x1, r_s10_x2;
    logic [31:0] w10_m;
    assign w10_m = r_s9_x1 * bpc_pkg::K_3038;

    // ---------------- stage 11: output register
    logic [31:0] w11_s, w11_pres;
    logic [31:0] r_otemp, r_opres;
    logic        r_oerr;
    assign w11_s    = r_s10_x1 + r_s10_x2 + bpc_pkg::K_3791;
    assign w11_pres = r_s10_p + 32'($signed(w11_s) >>> 4);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s9_v  <= 1'b0;
            r_s10_v <= 1'b0;
            r_ov    <= 1'b0;
        end else if (w_en) begin
            r_s9_v  <= r_pv[N];
            r_s10_v <= r_s9_v;
            r_ov    <= r_s10_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s9_err   <= r_ps[N].err;
            r_s9_temp  <= r_ps[N].temp;
            r_s9_p     <= w9_p;
            r_s9_x1    <= w9_ps * w9_ps;
            r_s9_x2    <= bpc_pkg::K_M7357 * w9_p;

            r_s10_err  <= r_s9_err;
            r_s10_temp <= r_s9_temp;
            r_s10_p    <= r_s9_p;
            r_s10_x1   <= 32'($signed(w10_m) >>> 16);
            r_s10_x2   <= 32'($signed(r_s9_x2) >>> 16);

            r_oerr     <= r_s10_err;
            r_otemp    <= r_s10_err ? 32'd0 : r_s10_temp;
            r_opres    <= r_s10_err ? 32'd0 : w11_pres;
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = {r_opres, r_otemp};
    assign m_axis_tuser  = r_oerr;

    // ---------------- assertions
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == 64'd0)
        else $error("error result carries nonzero data");

    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
        else $error("input taken while output stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid straight after reset");

endmodule

`default_nettype wire

[dv/baro_comp_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// baro_comp_checker
// Watches the request and result channels, works out the compensated
// temperature and pressure for each accepted request and compares them with
// the results in order. Calibration is mirrored from the APB writes.
// ----------------------------------------------------------------------------
`default_nettype none

module baro_comp_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    input  wire logic        s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,   // raw_temperature, raw_pressure
    input  wire logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    input  wire logic [63:0] m_axis_tdata,   // temperature_tenths, pressure_pa
    input  wire logic [0:0]  m_axis_tuser,   // div_error
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [63:0] pwdata,
    input  wire logic        pready,
    output int               o_fail_count,
    output int               o_pending
);

    typedef struct packed {
        logic [31:0] temp;
        logic [31:0] pres;
        logic        err;
    } t_comp;

    logic [63:0] cal0, cal1;
    logic [31:0] mcmd;
    logic [1:0]  oss;
    t_comp       comp_q[$];

    function automatic logic [31:0] sx16(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    function automatic logic [31:0] asr(input logic [31:0] v, input int s);
        return $unsigned($signed(v) >>> s);
    endfunction

    function automatic logic [31:0] sdiv(input logic [31:0] n, input logic [31:0] d);
        logic [31:0] an, ad, q;
        an = n[31] ? -n : n;
        ad = d[31] ? -d : d;
        q  = an / ad;
        return (n[31] != d[31]) ? -q : q;
    endfunction

    function automatic t_comp compensate(input logic [15:0] ut16, input logic [18:0] up19);
        t_comp r;
        logic [31:0] ut, up, ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
        logic [31:0] x1, x2, x3, b3, b4, b5, b6, b7, p, sq, dv;
        ut  = {16'd0, ut16};
        up  = {13'd0, up19};
        ac1 = sx16(cal0[15:0]);
        ac2 = sx16(cal0[31:16]);
        ac3 = sx16(cal0[47:32]);
        ac4 = {16'd0, cal0[63:48]};
        ac5 = {16'd0, cal1[15:0]};
        ac6 = {16'd0, cal1[31:16]};
        b1  = sx16(cal1[47:32]);
        b2  = sx16(cal1[63:48]);
        mc  = sx16(mcmd[15:0]);
        md  = sx16(mcmd[31:16]);
        r   = '{temp: 32'd0, pres: 32'd0, err: 1'b1};
        x1  = asr((ut - ac6) * ac5, 15);
        dv  = x1 + md;
        if (dv == 0) return r;
        x2  = sdiv(mc << 11, dv);
        b5  = x1 + x2;
        r.temp = asr(b5 + 32'd8, 4);
        b6  = b5 - bpc_pkg::B6_OFS;
        sq  = asr(b6 * b6, 12);
        x1  = asr(b2 * sq, 11);
        x2  = asr(ac2 * b6, 11);
        x3  = x1 + x2;
        b3  = asr((((ac1 << 2) + x3) << oss) + 32'd2, 2);
        x1  = asr(ac3 * b6, 13);
        x2  = asr(b1 * sq, 16);
        x3  = asr(x1 + x2 + 32'd2, 2);
        b4  = (ac4 * (x3 + bpc_pkg::B4_OFS)) >> 15;
        if (b4 == 0) begin
            r.temp = 32'd0;
            return r;
        end
        b7  = (up - b3) * (bpc_pkg::PRESS_K >> oss);
        p   = (b7 < 32'h8000_0000) ? ((b7 << 1) / b4) : ((b7 / b4) << 1);
        x1  = asr(p, 8) * asr(p, 8);
        x1  = asr(x1 * bpc_pkg::K_3038, 16);
        x2  = asr(bpc_pkg::K_M7357 * p, 16);
        r.pres = p + asr(x1 + x2 + bpc_pkg::K_3791, 4);
        r.err  = 1'b0;
        return r;
    endfunction

    assign o_pending = comp_q.size();

    always_ff @(posedge i_clk) begin
        t_comp want, got;
        if (!i_rst_n) begin
            cal0 <= '0;
            cal1 <= '0;
            mcmd <= '0;
            oss  <= '0;
            o_fail_count <= 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[4:3])
                    bpc_pkg::REG_CAL0: cal0 <= pwdata;
                    bpc_pkg::REG_CAL1: cal1 <= pwdata;
                    bpc_pkg::REG_MCMD: mcmd <= pwdata[31:0];
                    bpc_pkg::REG_OSS:  oss  <= pwdata[1:0];
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
                comp_q.push_back(compensate(s_axis_tdata[15:0], s_axis_tdata[34:16]));
            if (m_axis_tvalid && m_axis_tready) begin
                got = '{temp: m_axis_tdata[31:0], pres: m_axis_tdata[63:32],
                        err: m_axis_tuser[0]};
                if (comp_q.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %h", $time, got);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = comp_q.pop_front();
                    if (want != got) begin
                        $display({"%0t: mismatch expected temp %0d pres %0d err %0d,",
                                  " actual temp %0d pres %0d err %0d"},
                                 $time, $signed(want.temp), $signed(want.pres), want.err,
                                 $signed(got.temp), $signed(got.pres), got.err);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

`default_nettype wire

[dv/baro_pressure_temp_compensation_unit_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// baro_pressure_temp_compensation_unit_tb
// Drives raw sample requests under several calibration sets with random
// gaps and back-pressure; the checker predicts and compares each result.
// ----------------------------------------------------------------------------
`default_nettype none

module baro_pressure_temp_compensation_unit_tb;

    localparam int LATENCY   = 75;
    localparam int CYCLE_MAX = 400000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;   // raw_temperature, raw_pressure
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;        // temperature_tenths, pressure_pa
    logic [0:0]  m_axis_tuser;        // div_error
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic        pready;
    int          fail_count, pending;
    int          cycles = 0;
    bit          calm = 1'b0;

    always #5 i_clk = ~i_clk;

    baro_pressure_temp_compensation_unit u_top (.*);

    baro_comp_checker u_chk (
        .i_clk, .i_rst_n, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
        .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_MAX) begin
            $display("status: fail");
            $finish;
        end
    end

    // result side back-pressure
    always @(posedge i_clk)
        m_axis_tready <= calm || ($urandom_range(99) >= 26);

    task automatic reg_write(input logic [1:0] idx, input logic [63:0] val);
        @(posedge i_clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 3'b000}; pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    // tvalid stays high after the last accept; the next request or drain
    // decides its value, so it is driven once per edge
    task automatic send_sample(input logic [15:0] ut, input logic [18:0] up);
        while (!calm && $urandom_range(99) < 26) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'd0, up, ut};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    task automatic drain;
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
    endtask

    // calibration sets: typical sensor, random, extremes
    task automatic load_cal(input int kind);
        case (kind)
            0: begin
                reg_write(bpc_pkg::REG_CAL0, {16'd32741, 16'hC7A9, 16'hFBC8, 16'd408});
                reg_write(bpc_pkg::REG_CAL1, {16'd4, 16'd6190, 16'd23153, 16'd32757});
                reg_write(bpc_pkg::REG_MCMD, {32'd0, 16'd2868, 16'hD4BD});
            end
            1: begin
                reg_write(bpc_pkg::REG_CAL0, {$urandom, $urandom});
                reg_write(bpc_pkg::REG_CAL1, {$urandom, $urandom});
                reg_write(bpc_pkg::REG_MCMD, {32'd0, $urandom});
            end
            2: begin
                reg_write(bpc_pkg::REG_CAL0, '1);
                reg_write(bpc_pkg::REG_CAL1, '1);
                reg_write(bpc_pkg::REG_MCMD, 64'h0000_0000_FFFF_FFFF);
            end
            default: begin
                reg_write(bpc_pkg::REG_CAL0, 64'h8000_8000_8000_8000);
                reg_write(bpc_pkg::REG_CAL1, 64'h8000_8000_8000_8000);
                reg_write(bpc_pkg::REG_MCMD, 64'h0000_0000_7FFF_8000);
            end
        endcase
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // all-zero calibration: temperature divisor zero
        send_sample(16'd0, 19'd0);
        send_sample(16'hFFFF, 19'h7FFFF);
        drain;
        // ac4 zero with valid temperature path: pressure divisor zero
        reg_write(bpc_pkg::REG_MCMD, {32'd0, 16'd2868, 16'hD4BD});
        reg_write(bpc_pkg::REG_CAL1, {16'd4, 16'd6190, 16'd23153, 16'd32757});
        send_sample(16'd27898, 19'd23843);
        drain;
        for (int k = 0; k < 4; k++) begin
            load_cal(k);
            for (int o = 0; o < 4; o++) begin
                reg_write(bpc_pkg::REG_OSS, {62'd0, o[1:0]});
                send_sample(16'd27898, 19'd23843);
                send_sample(16'd0, 19'd0);
                send_sample(16'hFFFF, 19'h7FFFF);
                send_sample(16'h8000, 19'h40000);
                drain;
            end
        end
        for (int ph = 0; ph < 12; ph++) begin
            load_cal(ph % 6 < 3 ? (ph % 2 == 0 ? 0 : 1) : ph % 4);
            reg_write(bpc_pkg::REG_OSS, {62'd0, 2'($urandom_range(3))});
            calm = (ph == 5);
            for (int n = 0; n < 150; n++) begin
                if (ph % 2 == 0)
                    send_sample(16'(27898 + $urandom_range(4000) - 2000),
                                19'(23843 + $urandom_range(60000)));
                else
                    send_sample(16'($urandom), 19'($urandom));
            end
            calm = 1'b0;
            drain;
        end
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule

`default_nettype wire
